### sv/rvfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvfd_pkg
// Shared opcodes, function codes, mnemonic codes, stage payload types and
// the small decode tables of the instruction field decoder.
// ----------------------------------------------------------------------------
package rvfd_pkg;

    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_JAL    = 7'b1101111;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [5:0] HI6_LOGICAL = 6'b000000;
    localparam logic [5:0] SRA_HI6     = 6'b010000;

    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SL  = 3'd1;
    localparam logic [2:0] F3_SR  = 3'd5;

    localparam logic [5:0] MN_INVALID = 6'd0;
    localparam logic [5:0] MN_ADD  = 6'd1;
    localparam logic [5:0] MN_SUB  = 6'd2;
    localparam logic [5:0] MN_XOR  = 6'd3;
    localparam logic [5:0] MN_OR   = 6'd4;
    localparam logic [5:0] MN_AND  = 6'd5;
    localparam logic [5:0] MN_SLL  = 6'd6;
    localparam logic [5:0] MN_SRL  = 6'd7;
    localparam logic [5:0] MN_SRA  = 6'd8;
    localparam logic [5:0] MN_LB   = 6'd9;
    localparam logic [5:0] MN_LH   = 6'd10;
    localparam logic [5:0] MN_LW   = 6'd11;
    localparam logic [5:0] MN_LD   = 6'd12;
    localparam logic [5:0] MN_LBU  = 6'd13;
    localparam logic [5:0] MN_LHU  = 6'd14;
    localparam logic [5:0] MN_LWU  = 6'd15;
    localparam logic [5:0] MN_ADDI = 6'd16;
    localparam logic [5:0] MN_XORI = 6'd17;
    localparam logic [5:0] MN_ORI  = 6'd18;
    localparam logic [5:0] MN_ANDI = 6'd19;
    localparam logic [5:0] MN_SLLI = 6'd20;
    localparam logic [5:0] MN_SRLI = 6'd21;
    localparam logic [5:0] MN_SRAI = 6'd22;
    localparam logic [5:0] MN_JALR = 6'd23;
    localparam logic [5:0] MN_SB   = 6'd24;
    localparam logic [5:0] MN_SH   = 6'd25;
    localparam logic [5:0] MN_SW   = 6'd26;
    localparam logic [5:0] MN_SD   = 6'd27;
    localparam logic [5:0] MN_BEQ  = 6'd28;
    localparam logic [5:0] MN_BNE  = 6'd29;
    localparam logic [5:0] MN_BLT  = 6'd30;
    localparam logic [5:0] MN_BGE  = 6'd31;
    localparam logic [5:0] MN_BLTU = 6'd32;
    localparam logic [5:0] MN_BGEU = 6'd33;
    localparam logic [5:0] MN_LUI  = 6'd34;
    localparam logic [5:0] MN_JAL  = 6'd35;

    typedef enum logic [2:0] {
        FMT_R    = 3'd0,
        FMT_I    = 3'd1,
        FMT_S    = 3'd2,
        FMT_B    = 3'd3,
        FMT_U    = 3'd4,
        FMT_J    = 3'd5,
        FMT_NONE = 3'd6
    } fmt_t;

    typedef enum logic [3:0] {
        CLS_REG,
        CLS_LOAD,
        CLS_IMM,
        CLS_JALR,
        CLS_STORE,
        CLS_BRANCH,
        CLS_LUI,
        CLS_JAL,
        CLS_NONE
    } opcls_t;

    // first stage: raw word plus opcode class
    typedef struct packed {
        logic [31:0] word;
        opcls_t      cls;
    } rvfd_s1_t;

    // second stage: classified instruction
    typedef struct packed {
        logic [5:0]         mnemonic;
        fmt_t               format;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [20:0] immediate;
        logic               is_control_transfer;
    } rvfd_s2_t;

    // result as it sits on the output bus, lowest field in the lowest bits
    typedef struct packed {
        logic [6:0]         pad;
        logic               is_control_transfer;
        logic signed [18:0] target_offset_words;
        logic signed [20:0] immediate;
        logic [4:0]         src2_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         dest_reg;
        logic [2:0]         format;
        logic [5:0]         mnemonic;
    } rvfd_result_t;

    function automatic logic [5:0] load_mn(input logic [2:0] f3);
        logic [5:0] mn;
        case (f3)
            3'd0:    mn = MN_LB;
            3'd1:    mn = MN_LH;
            3'd2:    mn = MN_LW;
            3'd3:    mn = MN_LD;
            3'd4:    mn = MN_LBU;
            3'd5:    mn = MN_LHU;
            3'd6:    mn = MN_LWU;
            default: mn = MN_INVALID;
        endcase
        return mn;
    endfunction

    function automatic logic [5:0] store_mn(input logic [2:0] f3);
        logic [5:0] mn;
        case (f3)
            3'd0:    mn = MN_SB;
            3'd1:    mn = MN_SH;
            3'd2:    mn = MN_SW;
            3'd3:    mn = MN_SD;
            default: mn = MN_INVALID;
        endcase
        return mn;
    endfunction

    function automatic logic [5:0] branch_mn(input logic [2:0] f3);
        logic [5:0] mn;
        case (f3)
            3'd0:    mn = MN_BEQ;
            3'd1:    mn = MN_BNE;
            3'd4:    mn = MN_BLT;
            3'd5:    mn = MN_BGE;
            3'd6:    mn = MN_BLTU;
            3'd7:    mn = MN_BGEU;
            default: mn = MN_INVALID;
        endcase
        return mn;
    endfunction

    function automatic logic [5:0] alu_mn(input logic [2:0] f3);
        logic [5:0] mn;
        case (f3)
            3'd0:    mn = MN_ADD;
            3'd1:    mn = MN_SLL;
            3'd4:    mn = MN_XOR;
            3'd5:    mn = MN_SRL;
            3'd6:    mn = MN_OR;
            3'd7:    mn = MN_AND;
            default: mn = MN_INVALID;
        endcase
        return mn;
    endfunction

    function automatic logic [5:0] alui_mn(input logic [2:0] f3);
        logic [5:0] mn;
        case (f3)
            3'd0:    mn = MN_ADDI;
            3'd1:    mn = MN_SLLI;
            3'd4:    mn = MN_XORI;
            3'd5:    mn = MN_SRLI;
            3'd6:    mn = MN_ORI;
            3'd7:    mn = MN_ANDI;
            default: mn = MN_INVALID;
        endcase
        return mn;
    endfunction

endpackage

### sv/rvfd_opcode_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvfd_opcode_stage
// First pipeline stage: registers the instruction word together with its
// opcode class.
// ----------------------------------------------------------------------------
module rvfd_opcode_stage
    import rvfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_word,
    output logic        out_valid,
    input  logic        out_ready,
    output rvfd_s1_t    out_data
);

    logic     valid_reg;
    rvfd_s1_t data_reg;
    rvfd_s1_t data_next;

    always_comb
    begin
        data_next.word = in_word;
        case (in_word[6:0])
            OP_REG:    data_next.cls = CLS_REG;
            OP_LOAD:   data_next.cls = CLS_LOAD;
            OP_IMM:    data_next.cls = CLS_IMM;
            OP_JALR:   data_next.cls = CLS_JALR;
            OP_STORE:  data_next.cls = CLS_STORE;
            OP_BRANCH: data_next.cls = CLS_BRANCH;
            OP_LUI:    data_next.cls = CLS_LUI;
            OP_JAL:    data_next.cls = CLS_JAL;
            default:   data_next.cls = CLS_NONE;
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### sv/rvfd_classify_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvfd_classify_stage
// Second pipeline stage: picks the mnemonic from the function codes and
// builds the immediate for the format.
// ----------------------------------------------------------------------------
module rvfd_classify_stage
    import rvfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rvfd_s1_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output rvfd_s2_t out_data
);

    logic     valid_reg;
    rvfd_s2_t data_reg;
    rvfd_s2_t data_next;

    logic [31:0]        w;
    logic [2:0]         f3;
    logic [6:0]         f7;
    logic [5:0]         hi6;
    logic signed [20:0] imm_i;

    assign w     = in_data.word;
    assign f3    = w[14:12];
    assign f7    = w[31:25];
    assign hi6   = w[31:26];
    assign imm_i = {{9{w[31]}}, w[31:20]};

    always_comb
    begin
        data_next.mnemonic            = MN_INVALID;
        data_next.format              = FMT_NONE;
        data_next.dest_reg            = w[11:7];
        data_next.src1_reg            = w[19:15];
        data_next.src2_reg            = w[24:20];
        data_next.immediate           = '0;
        data_next.is_control_transfer = 1'b0;
        case (in_data.cls)
            CLS_REG:
            begin
                data_next.format = FMT_R;
                if (f7 == F7_BASE)
                begin
                    data_next.mnemonic = alu_mn(f3);
                end
                else if (f7 == F7_ALT && f3 == F3_ADD)
                begin
                    data_next.mnemonic = MN_SUB;
                end
                else if (f7 == F7_ALT && f3 == F3_SR)
                begin
                    data_next.mnemonic = MN_SRA;
                end
            end
            CLS_LOAD:
            begin
                data_next.format    = FMT_I;
                data_next.immediate = imm_i;
                data_next.mnemonic  = load_mn(f3);
            end
            CLS_JALR:
            begin
                data_next.format    = FMT_I;
                data_next.immediate = imm_i;
                data_next.mnemonic  = MN_JALR;
            end
            CLS_IMM:
            begin
                data_next.format    = FMT_I;
                data_next.immediate = imm_i;
                if (f3 == F3_SL || f3 == F3_SR)
                begin
                    if (hi6 == HI6_LOGICAL)
                    begin
                        data_next.mnemonic = alui_mn(f3);
                    end
                    else if (f3 == F3_SR && hi6 == SRA_HI6)
                    begin
                        // srai carries the bare shift amount
                        data_next.mnemonic  = MN_SRAI;
                        data_next.immediate = {15'd0, w[25:20]};
                    end
                end
                else
                begin
                    data_next.mnemonic = alui_mn(f3);
                end
            end
            CLS_STORE:
            begin
                data_next.format    = FMT_S;
                data_next.immediate = {{9{w[31]}}, w[31:25], w[11:7]};
                data_next.mnemonic  = store_mn(f3);
            end
            CLS_BRANCH:
            begin
                data_next.format              = FMT_B;
                data_next.immediate           = {{8{w[31]}}, w[31], w[7], w[30:25],
                                                 w[11:8], 1'b0};
                data_next.mnemonic            = branch_mn(f3);
                data_next.is_control_transfer = 1'b1;
            end
            CLS_LUI:
            begin
                data_next.format    = FMT_U;
                data_next.immediate = {1'b0, w[31:12]};
                data_next.mnemonic  = MN_LUI;
            end
            CLS_JAL:
            begin
                data_next.format              = FMT_J;
                data_next.immediate           = {w[31], w[19:12], w[20], w[30:21], 1'b0};
                data_next.mnemonic            = MN_JAL;
                data_next.is_control_transfer = 1'b1;
            end
            default:
            begin
                data_next.format = FMT_NONE;
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### sv/rvfd_offset_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvfd_offset_stage
// Third pipeline stage: turns the branch or jal byte offset into a word
// offset and holds the packed result for the output bus.
// ----------------------------------------------------------------------------
module rvfd_offset_stage
    import rvfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  rvfd_s2_t     in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output rvfd_result_t out_data
);

    logic               valid_reg;
    rvfd_result_t       data_reg;
    rvfd_result_t       data_next;
    logic signed [20:0] biased;

    // add 3 to negative offsets so the shift truncates toward zero
    assign biased = in_data.immediate + {19'd0, {2{in_data.immediate[20]}}};

    always_comb
    begin
        data_next.pad                 = '0;
        data_next.is_control_transfer = in_data.is_control_transfer;
        data_next.target_offset_words = in_data.is_control_transfer ? biased[20:2] : '0;
        data_next.immediate           = in_data.immediate;
        data_next.src2_reg            = in_data.src2_reg;
        data_next.src1_reg            = in_data.src1_reg;
        data_next.dest_reg            = in_data.dest_reg;
        data_next.format              = in_data.format;
        data_next.mnemonic            = in_data.mnemonic;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### sv/rv_instruction_field_decoder.sv
`timescale 1ns / 1ps
// an input transfer passes the opcode, classify and offset stage registers before it shows on m_axis
// throughput: one instruction per cycle unless m_axis_tready stalls the output, set by the three register stages
// each stage holds while its successor is full and stalled, so nothing drops
// reset: rst_n clears the stage valid bits at once; the pipeline starts empty
// ----------------------------------------------------------------------------
// rv_instruction_field_decoder
// Three-stage decoder for one RV64I instruction word per transfer: opcode
// class, mnemonic and immediate, then word offset of branches and jal.
// ----------------------------------------------------------------------------
module rv_instruction_field_decoder
    import rvfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // instruction_word[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mnemonic[5:0], format[8:6], dest_reg[13:9], src1_reg[18:14],
    // src2_reg[23:19], immediate[44:24], target_offset_words[63:45],
    // is_control_transfer[64], zero[71:65]
    output logic [71:0] m_axis_tdata
);

    logic         s1_valid;
    logic         s1_ready;
    rvfd_s1_t     s1_data;
    logic         s2_valid;
    logic         s2_ready;
    rvfd_s2_t     s2_data;
    rvfd_result_t result;

    rvfd_opcode_stage u_opcode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_word   (s_axis_tdata),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    rvfd_classify_stage u_classify
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    rvfd_offset_stage u_offset
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (result)
    );

    assign m_axis_tdata = result;

endmodule

### sv/rvfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvfd_checker
// Port-level checks of the instruction field decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rvfd_checker
    import rvfd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output payload changed while stalled");

    // input backpressure only when every stage is full and the output stalls
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while the pipeline could move");

    // lui passes through the opcode, classify and offset stages when the output keeps taking
    a_lui_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[6:0] == OP_LUI)
        ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid && m_axis_tdata[5:0] == MN_LUI)
        else $error("lui result missing or wrong after three cycles");

    // unknown opcode carries no mnemonic, immediate or offset
    a_unknown_opcode: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[8:6] == FMT_NONE
        |-> m_axis_tdata[5:0] == MN_INVALID && m_axis_tdata[64:24] == '0)
        else $error("unknown opcode gave nonzero fields");

endmodule

bind rv_instruction_field_decoder rvfd_checker u_rvfd_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rv_instruction_field_decoder. A directed set of
// instruction words covers every opcode, valid and invalid function codes and the field
// extremes. Random words follow, mostly with known opcodes. Each transfer is
// decoded by a local predictor and checked field by field against the output
// stream, under bursty input, a stalling receiver and one long hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import rvfd_pkg::*;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_HEAVY
    } rx_mode_t;

    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTED = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    rvfd_result_t decoded_q[$];
    int           err_count = 0;
    rx_mode_t     rx_mode = RX_ALWAYS;
    int           gap_max = 0;
    int           burst_left = 0;
    int           hold_requests = 0;
    int           hold_served = 0;

    rv_instruction_field_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // expected decode of one instruction word
    function automatic rvfd_result_t decode_instruction(input logic [31:0] w);
        rvfd_result_t r;
        logic [6:0]   op;
        logic [2:0]   f3;
        logic [6:0]   f7;
        logic [5:0]   hi6;
        logic [12:0]  boff;
        logic [20:0]  joff;
        int           imm;
        int           tgt;
        op   = w[6:0];
        f3   = w[14:12];
        f7   = w[31:25];
        hi6  = w[31:26];
        imm  = 0;
        tgt  = 0;
        r    = '0;
        r.mnemonic = MN_INVALID;
        r.format   = FMT_NONE;
        r.dest_reg = w[11:7];
        r.src1_reg = w[19:15];
        r.src2_reg = w[24:20];
        case (op)
            OP_REG:
            begin
                r.format = FMT_R;
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        3'd0: r.mnemonic = MN_ADD;
                        3'd1: r.mnemonic = MN_SLL;
                        3'd4: r.mnemonic = MN_XOR;
                        3'd5: r.mnemonic = MN_SRL;
                        3'd6: r.mnemonic = MN_OR;
                        3'd7: r.mnemonic = MN_AND;
                        default: r.mnemonic = MN_INVALID;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    r.mnemonic = MN_SUB;
                else if (f7 == F7_ALT && f3 == F3_SR)
                    r.mnemonic = MN_SRA;
            end
            OP_LOAD:
            begin
                r.format = FMT_I;
                imm = $signed(w[31:20]);
                case (f3)
                    3'd0: r.mnemonic = MN_LB;
                    3'd1: r.mnemonic = MN_LH;
                    3'd2: r.mnemonic = MN_LW;
                    3'd3: r.mnemonic = MN_LD;
                    3'd4: r.mnemonic = MN_LBU;
                    3'd5: r.mnemonic = MN_LHU;
                    3'd6: r.mnemonic = MN_LWU;
                    default: r.mnemonic = MN_INVALID;
                endcase
            end
            OP_JALR:
            begin
                r.format   = FMT_I;
                imm        = $signed(w[31:20]);
                r.mnemonic = MN_JALR;
            end
            OP_IMM:
            begin
                r.format = FMT_I;
                imm = $signed(w[31:20]);
                case (f3)
                    3'd0: r.mnemonic = MN_ADDI;
                    3'd4: r.mnemonic = MN_XORI;
                    3'd6: r.mnemonic = MN_ORI;
                    3'd7: r.mnemonic = MN_ANDI;
                    F3_SL:
                        if (hi6 == HI6_LOGICAL)
                            r.mnemonic = MN_SLLI;
                    F3_SR:
                        if (hi6 == HI6_LOGICAL)
                            r.mnemonic = MN_SRLI;
                        else if (hi6 == SRA_HI6)
                        begin
                            r.mnemonic = MN_SRAI;
                            imm = int'(w[25:20]);
                        end
                    default: r.mnemonic = MN_INVALID;
                endcase
            end
            OP_STORE:
            begin
                r.format = FMT_S;
                imm = $signed({w[31:25], w[11:7]});
                case (f3)
                    3'd0: r.mnemonic = MN_SB;
                    3'd1: r.mnemonic = MN_SH;
                    3'd2: r.mnemonic = MN_SW;
                    3'd3: r.mnemonic = MN_SD;
                    default: r.mnemonic = MN_INVALID;
                endcase
            end
            OP_BRANCH:
            begin
                r.format = FMT_B;
                boff = {w[31], w[7], w[30:25], w[11:8], 1'b0};
                imm  = $signed(boff);
                tgt  = imm / 4;
                r.is_control_transfer = 1'b1;
                case (f3)
                    3'd0: r.mnemonic = MN_BEQ;
                    3'd1: r.mnemonic = MN_BNE;
                    3'd4: r.mnemonic = MN_BLT;
                    3'd5: r.mnemonic = MN_BGE;
                    3'd6: r.mnemonic = MN_BLTU;
                    3'd7: r.mnemonic = MN_BGEU;
                    default: r.mnemonic = MN_INVALID;
                endcase
            end
            OP_LUI:
            begin
                r.format   = FMT_U;
                r.mnemonic = MN_LUI;
                imm        = int'(w[31:12]);
            end
            OP_JAL:
            begin
                r.format   = FMT_J;
                r.mnemonic = MN_JAL;
                joff = {w[31], w[19:12], w[20], w[30:21], 1'b0};
                imm  = $signed(joff);
                tgt  = imm / 4;
                r.is_control_transfer = 1'b1;
            end
            default:
                r.format = FMT_NONE;
        endcase
        r.immediate           = imm[20:0];
        r.target_offset_words = tgt[18:0];
        return r;
    endfunction

    function automatic logic [31:0] rtype(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OP_REG};
    endfunction

    function automatic logic [31:0] itype(input logic [6:0] op, input logic [11:0] imm,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] stype(input logic [2:0] f3, input logic [11:0] imm,
                                          input logic [4:0] rs2, input logic [4:0] rs1);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] btype(input logic [2:0] f3, input logic [12:0] off,
                                          input logic [4:0] rs2, input logic [4:0] rs1);
        return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] jtype(input logic [20:0] off, input logic [4:0] rd);
        return {off[20], off[10:1], off[11], off[19:12], rd, OP_JAL};
    endfunction

    // mostly well-formed opcodes with random content, the rest pure noise
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        int          pick;
        w = $urandom;
        if ($urandom_range(0, 99) < 85)
        begin
            pick = $urandom_range(0, 7);
            case (pick)
                0:
                begin
                    w[6:0] = OP_REG;
                    case ($urandom_range(0, 3))
                        0, 1: w[31:25] = F7_BASE;
                        2: w[31:25] = F7_ALT;
                        default: ;
                    endcase
                end
                1: w[6:0] = OP_LOAD;
                2:
                begin
                    w[6:0] = OP_IMM;
                    case ($urandom_range(0, 3))
                        0, 1: w[31:26] = HI6_LOGICAL;
                        2: w[31:26] = SRA_HI6;
                        default: ;
                    endcase
                end
                3: w[6:0] = OP_JALR;
                4: w[6:0] = OP_STORE;
                5: w[6:0] = OP_BRANCH;
                6: w[6:0] = OP_LUI;
                default: w[6:0] = OP_JAL;
            endcase
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < MAX_PRINTED)
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // one instruction transfer, then an idle gap once the current burst is used up
    task automatic send_word(input logic [31:0] w);
        int gap;
        s_axis_tdata  = w;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        decoded_q.push_back(decode_instruction(w));
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // receiver stall pattern, with a long hold-off on request
    always @(negedge clk)
    begin
        static int hold_left = 0;
        static int cyc = 0;
        cyc++;
        if (hold_left == 0 && hold_requests != hold_served)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready = 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS: m_axis_tready = 1'b1;
                RX_RANDOM: m_axis_tready = ($urandom_range(0, 3) != 0);
                RX_PERIODIC: m_axis_tready = ((cyc % 5) < 3);
                default: m_axis_tready = ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    // compare each output transfer with the oldest expected decode
    always @(posedge clk)
    begin
        rvfd_result_t got;
        rvfd_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = rvfd_result_t'(m_axis_tdata);
            if (decoded_q.size() == 0)
                report_mismatch("unexpected transfer", m_axis_tdata[31:0], '0);
            else
            begin
                want = decoded_q.pop_front();
                if (got.mnemonic !== want.mnemonic)
                    report_mismatch("mnemonic", 32'(got.mnemonic), 32'(want.mnemonic));
                if (got.format !== want.format)
                    report_mismatch("format", 32'(got.format), 32'(want.format));
                if (got.dest_reg !== want.dest_reg)
                    report_mismatch("dest_reg", 32'(got.dest_reg), 32'(want.dest_reg));
                if (got.src1_reg !== want.src1_reg)
                    report_mismatch("src1_reg", 32'(got.src1_reg), 32'(want.src1_reg));
                if (got.src2_reg !== want.src2_reg)
                    report_mismatch("src2_reg", 32'(got.src2_reg), 32'(want.src2_reg));
                if (got.immediate !== want.immediate)
                    report_mismatch("immediate", 32'(got.immediate), 32'(want.immediate));
                if (got.target_offset_words !== want.target_offset_words)
                    report_mismatch("target_offset_words", 32'(got.target_offset_words),
                                    32'(want.target_offset_words));
                if (got.is_control_transfer !== want.is_control_transfer)
                    report_mismatch("is_control_transfer", 32'(got.is_control_transfer),
                                    32'(want.is_control_transfer));
                if (got.pad !== '0)
                    report_mismatch("padding", 32'(got.pad), '0);
            end
        end
    end

    task automatic test_directed();
        rx_mode = RX_RANDOM;
        gap_max = 3;
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(rtype(F7_BASE, 5'd31, 5'd0, F3_ADD, 5'd31));
        send_word(rtype(F7_ALT, 5'd0, 5'd31, F3_ADD, 5'd0));
        send_word(rtype(F7_ALT, 5'd7, 5'd9, F3_SR, 5'd3));
        // alternate funct7 is only defined for sub and sra
        send_word(rtype(F7_ALT, 5'd1, 5'd2, F3_SL, 5'd4));
        send_word(rtype(F7_BASE, 5'd1, 5'd2, 3'd2, 5'd4));
        send_word(itype(OP_LOAD, 12'h800, 5'd31, 3'd0, 5'd1));
        send_word(itype(OP_LOAD, 12'h123, 5'd5, 3'd7, 5'd6));
        send_word(itype(OP_IMM, 12'h7FF, 5'd1, F3_ADD, 5'd2));
        send_word(itype(OP_IMM, {HI6_LOGICAL, 6'd63}, 5'd3, F3_SL, 5'd4));
        send_word(itype(OP_IMM, {HI6_LOGICAL, 6'd1}, 5'd3, F3_SR, 5'd4));
        send_word(itype(OP_IMM, {SRA_HI6, 6'd63}, 5'd8, F3_SR, 5'd9));
        // shifts with bad upper immediate bits fall back to the plain immediate
        send_word(itype(OP_IMM, {6'h3F, 6'd5}, 5'd8, F3_SR, 5'd9));
        send_word(itype(OP_IMM, {SRA_HI6, 6'd5}, 5'd8, F3_SL, 5'd9));
        send_word(itype(OP_JALR, 12'h800, 5'd1, 3'd7, 5'd0));
        send_word(stype(3'd3, 12'hFFF, 5'd31, 5'd30));
        send_word(stype(3'd4, 12'h800, 5'd2, 5'd3));
        send_word(btype(3'd0, 13'h1000, 5'd1, 5'd2));
        send_word(btype(3'd2, 13'h0FFE, 5'd3, 5'd4));
        // small negative offsets check truncation toward zero
        send_word(btype(3'd1, 13'h1FFE, 5'd5, 5'd6));
        send_word(btype(3'd4, 13'h1FFA, 5'd7, 5'd8));
        send_word({20'hFFFFF, 5'd31, OP_LUI});
        send_word(jtype(21'h100000, 5'd1));
        send_word(jtype(21'h1FFFFE, 5'd0));
        send_word(jtype(21'h0FFFFE, 5'd31));
    endtask

    task automatic test_streaming(input int count);
        rx_mode = RX_ALWAYS;
        gap_max = 0;
        repeat (count) send_word(random_word());
    endtask

    task automatic test_bursts(input int count);
        rx_mode = RX_RANDOM;
        gap_max = 6;
        repeat (count) send_word(random_word());
        rx_mode = RX_PERIODIC;
        gap_max = 2;
        repeat (count) send_word(random_word());
    endtask

    task automatic test_backpressure(input int count);
        rx_mode = RX_ALWAYS;
        gap_max = 0;
        hold_requests++;
        repeat (count) send_word(random_word());
    endtask

    task automatic test_heavy_stall(input int count);
        rx_mode = RX_HEAVY;
        gap_max = 4;
        repeat (count) send_word(random_word());
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_streaming(200);
        test_bursts(200);
        test_backpressure(150);
        test_heavy_stall(200);
        s_axis_tvalid = 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && decoded_q.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
